// File: design/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg: shared constants and types
// Sizes, widths and the sequencer state codes for the component pair counter.
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int MAX_EDGES    = 2048;

    localparam int VTX_W   = $clog2(MAX_VERTICES);
    localparam int CNT_W   = VTX_W + 1;
    localparam int EDGE_W  = $clog2(MAX_EDGES);
    localparam int FILL_W  = EDGE_W + 1;
    localparam int COLOR_W = VTX_W + 1;
    localparam int CIDX_W  = VTX_W + 2;
    localparam int STK_W   = VTX_W + FILL_W;
    localparam int OUT_W   = 12;
    localparam int IN_W    = 9;

    localparam int S_TDATA_W = ((2 * IN_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [OUT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [16:0] {
        ST_LOAD      = 17'h00001,
        ST_CLEAR     = 17'h00002,
        ST_P1_NEXT   = 17'h00004,
        ST_P1_WAIT   = 17'h00008,
        ST_P2_NEXT   = 17'h00010,
        ST_P2_FWAIT  = 17'h00020,
        ST_P2_CHK    = 17'h00040,
        ST_SCAN      = 17'h00080,
        ST_EDGE_CHK  = 17'h00100,
        ST_EDGE_TEST = 17'h00200,
        ST_POP_WAIT  = 17'h00400,
        ST_CNT_INIT  = 17'h00800,
        ST_CNT_SCAN  = 17'h01000,
        ST_CNT_EDGE  = 17'h02000,
        ST_CNT_COMP  = 17'h04000,
        ST_CNT_SEEN  = 17'h08000,
        ST_EMIT      = 17'h10000
    } state_t;

endpackage

// File: design/scc_ram.sv
// ----------------------------------------------------------------------------
// scc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module scc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/scc_condensation_edge_count.sv
// ----------------------------------------------------------------------------
// scc_condensation_edge_count: strongly connected component pair counter
// Loads a directed graph edge by edge, then finds its components with two
// depth-first walks and counts component pairs joined by an edge.
// ----------------------------------------------------------------------------
// Edge words load at one per cycle. After the word marked last the block
// drops s_tready and runs its sequencer: a clearing pass over all 256
// addresses resets the visited, component and pair mark memories; then each
// walk frame scans the whole edge store through one compare unit with an
// edge read, a mark read and a test per stored edge, in each of the two
// walks; the pair count then makes, per component, one edge read, one
// component lookup, one pair mark lookup and one compare per edge. One
// result word follows each graph; loading of the next graph starts while it
// waits on the master side.
module scc_condensation_edge_count (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [scc_pkg::CNT_W-1:0]           cfg_data,   // vertex_count
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [scc_pkg::S_TDATA_W-1:0]       s_tdata,    // src_vertex, dst_vertex
    input  logic                                s_tuser,    // edge_valid
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [scc_pkg::M_TDATA_W-1:0]       m_tdata,    // cross_pair_count
    output logic                                m_tuser     // load_error
);
    import scc_pkg::*;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       vcount_reg;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic                   err_reg, err_next;
    logic                   pass2_reg, pass2_next;
    logic [CNT_W-1:0]       i_reg, i_next;
    logic [CNT_W-1:0]       j_reg, j_next;
    logic [CNT_W-1:0]       done_reg, done_next;
    logic [COLOR_W-1:0]     color_reg, color_next;
    logic [CIDX_W-1:0]      c_reg, c_next;
    logic [FILL_W-1:0]      e_reg, e_next;
    logic [VTX_W-1:0]       cur_v_reg, cur_v_next;
    logic [FILL_W-1:0]      cur_pos_reg, cur_pos_next;
    logic [VTX_W-1:0]       sp_reg, sp_next;
    logic                   rng_reg, rng_next;
    logic [OUT_W-1:0]       count_reg, count_next;
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]       m_count_reg, m_count_next;
    logic                   m_err_reg, m_err_next;

    logic [CNT_W-1:0]       n_eff;
    logic [IN_W-1:0]        src_in, dst_in;
    logic                   s_fire;

    logic                   edge_we;
    logic [EDGE_W-1:0]      edge_waddr, edge_raddr;
    logic [2*VTX_W-1:0]     edge_wdata, edge_rdata;
    logic                   stk_we;
    logic [VTX_W-1:0]       stk_waddr, stk_raddr;
    logic [STK_W-1:0]       stk_wdata, stk_rdata;
    logic                   fin_we;
    logic [VTX_W-1:0]       fin_waddr, fin_raddr, fin_rdata;
    logic                   comp_we;
    logic [VTX_W-1:0]       comp_waddr, comp_raddr_a, comp_raddr_b;
    logic [COLOR_W-1:0]     comp_wdata, comp_rdata_a, comp_rdata_b;
    logic                   vis_we;
    logic [VTX_W-1:0]       vis_waddr, vis_raddr;
    logic                   vis_wdata, vis_rdata;
    logic                   seen_we;
    logic [VTX_W-1:0]       seen_waddr, seen_raddr;
    logic [COLOR_W-1:0]     seen_wdata, seen_rdata;

    logic [VTX_W-1:0]       e_tail, e_head, e_from, e_to;
    logic                   e_in_rng;
    logic [CIDX_W-1:0]      ca, cb, other_c;
    logic [VTX_W-1:0]       seen_idx;
    logic                   to_marked;
    logic                   pair_cand;

    assign n_eff = (vcount_reg > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vcount_reg;
    assign src_in = s_tdata[IN_W-1:0];
    assign dst_in = s_tdata[2*IN_W-1:IN_W];
    assign s_tready = (state_reg == ST_LOAD);
    assign s_fire = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign e_tail = edge_rdata[VTX_W-1:0];
    assign e_head = edge_rdata[2*VTX_W-1:VTX_W];
    assign e_from = pass2_reg ? e_head : e_tail;
    assign e_to   = pass2_reg ? e_tail : e_head;
    assign e_in_rng = ({1'b0, e_tail} < n_eff) && ({1'b0, e_head} < n_eff);
    assign ca = CIDX_W'(comp_rdata_a);
    assign cb = CIDX_W'(comp_rdata_b);
    assign to_marked = pass2_reg ? (ca != '0) : vis_rdata;
    assign other_c = (ca == c_reg) ? cb : ca;
    assign seen_idx = VTX_W'(other_c - 1'b1);
    assign pair_cand = rng_reg && ((ca == c_reg && cb > c_reg) ||
                                   (cb == c_reg && ca > c_reg));

    assign edge_raddr   = (state_reg inside {ST_CNT_SCAN, ST_CNT_EDGE, ST_CNT_COMP,
                                             ST_CNT_SEEN}) ? e_reg[EDGE_W-1:0]
                                                           : cur_pos_reg[EDGE_W-1:0];
    assign comp_raddr_a = (state_reg == ST_P2_FWAIT) ? fin_rdata : e_tail;
    assign comp_raddr_b = e_head;
    assign vis_raddr    = (state_reg == ST_P1_NEXT) ? i_reg[VTX_W-1:0] : e_head;
    assign seen_raddr   = seen_idx;

    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        err_next      = err_reg;
        pass2_next    = pass2_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        done_next     = done_reg;
        color_next    = color_reg;
        c_next        = c_reg;
        e_next        = e_reg;
        cur_v_next    = cur_v_reg;
        cur_pos_next  = cur_pos_reg;
        sp_next       = sp_reg;
        rng_next      = rng_reg;
        count_next    = count_reg;
        m_valid_next  = m_valid_reg;
        m_count_next  = m_count_reg;
        m_err_next    = m_err_reg;
        edge_we       = 1'b0;
        edge_waddr    = fill_reg[EDGE_W-1:0];
        edge_wdata    = {dst_in[VTX_W-1:0] - 1'b1, src_in[VTX_W-1:0] - 1'b1};
        stk_we        = 1'b0;
        stk_waddr     = sp_reg;
        stk_wdata     = {cur_pos_reg + 1'b1, cur_v_reg};
        stk_raddr     = sp_reg - 1'b1;
        fin_we        = 1'b0;
        fin_waddr     = done_reg[VTX_W-1:0];
        fin_raddr     = VTX_W'(j_reg - 1'b1);
        comp_we       = 1'b0;
        comp_waddr    = e_to;
        comp_wdata    = color_reg;
        vis_we        = 1'b0;
        vis_waddr     = e_to;
        vis_wdata     = 1'b1;
        seen_we       = 1'b0;
        seen_waddr    = seen_idx;
        seen_wdata    = COLOR_W'(c_reg);

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_LOAD: begin
                if (s_fire) begin
                    if (s_tuser) begin
                        if (src_in == '0 || {1'b0, src_in} > {1'b0, n_eff} ||
                            dst_in == '0 || {1'b0, dst_in} > {1'b0, n_eff} ||
                            fill_reg >= FILL_W'(MAX_EDGES)) begin
                            err_next = 1'b1;
                        end else begin
                            edge_we   = 1'b1;
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                    if (s_tlast) begin
                        i_next        = '0;
                        done_next     = '0;
                        color_next    = '0;
                        count_next    = '0;
                        sp_next       = '0;
                        pass2_next    = 1'b0;
                        state_next    = ST_CLEAR;
                    end
                end
            end
            ST_CLEAR: begin
                vis_we     = 1'b1;
                vis_waddr  = i_reg[VTX_W-1:0];
                vis_wdata  = 1'b0;
                comp_we    = 1'b1;
                comp_waddr = i_reg[VTX_W-1:0];
                comp_wdata = '0;
                seen_we    = 1'b1;
                seen_waddr = i_reg[VTX_W-1:0];
                seen_wdata = '0;
                if (i_reg == CNT_W'(MAX_VERTICES - 1)) begin
                    i_next     = '0;
                    state_next = ST_P1_NEXT;
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_P1_NEXT: begin
                if (i_reg == n_eff) begin
                    j_next     = done_reg;
                    pass2_next = 1'b1;
                    state_next = ST_P2_NEXT;
                end else begin
                    state_next = ST_P1_WAIT;
                end
            end
            ST_P1_WAIT: begin
                if (vis_rdata) begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_P1_NEXT;
                end else begin
                    vis_we       = 1'b1;
                    vis_waddr    = i_reg[VTX_W-1:0];
                    cur_v_next   = i_reg[VTX_W-1:0];
                    cur_pos_next = '0;
                    sp_next      = '0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cur_pos_reg == fill_reg) begin
                    if (!pass2_reg) begin
                        fin_we    = 1'b1;
                        done_next = done_reg + 1'b1;
                    end
                    if (sp_reg == '0) begin
                        if (pass2_reg) begin
                            j_next     = j_reg - 1'b1;
                            state_next = ST_P2_NEXT;
                        end else begin
                            i_next     = i_reg + 1'b1;
                            state_next = ST_P1_NEXT;
                        end
                    end else begin
                        sp_next    = sp_reg - 1'b1;
                        state_next = ST_POP_WAIT;
                    end
                end else begin
                    state_next = ST_EDGE_CHK;
                end
            end
            ST_EDGE_CHK: begin
                state_next = ST_EDGE_TEST;
            end
            ST_EDGE_TEST: begin
                cur_pos_next = cur_pos_reg + 1'b1;
                state_next   = ST_SCAN;
                if (e_in_rng && e_from == cur_v_reg && !to_marked) begin
                    if (pass2_reg) begin
                        comp_we = 1'b1;
                    end else begin
                        vis_we = 1'b1;
                    end
                    stk_we       = 1'b1;
                    sp_next      = sp_reg + 1'b1;
                    cur_v_next   = e_to;
                    cur_pos_next = '0;
                end
            end
            ST_POP_WAIT: begin
                cur_v_next   = stk_rdata[VTX_W-1:0];
                cur_pos_next = stk_rdata[STK_W-1:VTX_W];
                state_next   = ST_SCAN;
            end
            ST_P2_NEXT: begin
                if (j_reg == '0) begin
                    c_next     = CIDX_W'(1);
                    state_next = ST_CNT_INIT;
                end else begin
                    state_next = ST_P2_FWAIT;
                end
            end
            ST_P2_FWAIT: begin
                state_next = ST_P2_CHK;
            end
            ST_P2_CHK: begin
                if (ca != '0) begin
                    j_next     = j_reg - 1'b1;
                    state_next = ST_P2_NEXT;
                end else begin
                    color_next   = color_reg + 1'b1;
                    comp_we      = 1'b1;
                    comp_waddr   = fin_rdata;
                    comp_wdata   = color_reg + 1'b1;
                    cur_v_next   = fin_rdata;
                    cur_pos_next = '0;
                    sp_next      = '0;
                    state_next   = ST_SCAN;
                end
            end
            ST_CNT_INIT: begin
                if (c_reg > CIDX_W'(color_reg)) begin
                    state_next = ST_EMIT;
                end else begin
                    e_next     = '0;
                    state_next = ST_CNT_SCAN;
                end
            end
            ST_CNT_SCAN: begin
                if (e_reg == fill_reg) begin
                    c_next     = c_reg + 1'b1;
                    state_next = ST_CNT_INIT;
                end else begin
                    state_next = ST_CNT_EDGE;
                end
            end
            ST_CNT_EDGE: begin
                rng_next   = e_in_rng;
                state_next = ST_CNT_COMP;
            end
            ST_CNT_COMP: begin
                state_next = ST_CNT_SEEN;
            end
            ST_CNT_SEEN: begin
                e_next     = e_reg + 1'b1;
                state_next = ST_CNT_SCAN;
                if (pair_cand && seen_rdata != COLOR_W'(c_reg)) begin
                    seen_we = 1'b1;
                    if (count_reg != COUNT_MAX) begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_count_next = count_reg;
                    m_err_next   = err_reg;
                    fill_next    = '0;
                    err_next     = 1'b0;
                    state_next   = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            vcount_reg  <= CNT_W'(MAX_VERTICES);
            fill_reg    <= '0;
            err_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            pass2_reg   <= 1'b0;
            sp_reg      <= '0;
            color_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
            pass2_reg   <= pass2_next;
            sp_reg      <= sp_next;
            color_reg   <= color_next;
            if (cfg_valid && cfg_ready) begin
                vcount_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        done_reg     <= done_next;
        c_reg        <= c_next;
        e_reg        <= e_next;
        cur_v_reg    <= cur_v_next;
        cur_pos_reg  <= cur_pos_next;
        rng_reg      <= rng_next;
        count_reg    <= count_next;
        m_count_reg  <= m_count_next;
        m_err_reg    <= m_err_next;
    end

    scc_ram #(.WIDTH(2 * VTX_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .aclk(aclk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
        .raddr(edge_raddr), .rdata(edge_rdata)
    );

    scc_ram #(.WIDTH(STK_W), .DEPTH(MAX_VERTICES)) u_stack_ram (
        .aclk(aclk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    scc_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_finish_ram (
        .aclk(aclk), .we(fin_we), .waddr(fin_waddr), .wdata(cur_v_reg),
        .raddr(fin_raddr), .rdata(fin_rdata)
    );

    scc_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_VERTICES)) u_comp_ram_a (
        .aclk(aclk), .we(comp_we), .waddr(comp_waddr), .wdata(comp_wdata),
        .raddr(comp_raddr_a), .rdata(comp_rdata_a)
    );

    scc_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_VERTICES)) u_comp_ram_b (
        .aclk(aclk), .we(comp_we), .waddr(comp_waddr), .wdata(comp_wdata),
        .raddr(comp_raddr_b), .rdata(comp_rdata_b)
    );

    scc_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_visit_ram (
        .aclk(aclk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
        .raddr(vis_raddr), .rdata(vis_rdata)
    );

    scc_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_VERTICES)) u_seen_ram (
        .aclk(aclk), .we(seen_we), .waddr(seen_waddr), .wdata(seen_wdata),
        .raddr(seen_raddr), .rdata(seen_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_count_reg);
    assign m_tuser  = m_err_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(MAX_EDGES))
        else $error("edge fill beyond capacity");

    a_color_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        color_reg <= COLOR_W'(MAX_VERTICES))
        else $error("component count beyond vertex capacity");

    a_load_stack_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD) |-> (sp_reg == '0))
        else $error("walk stack not empty while loading");

    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && (!m_valid_reg || m_tready))
            |=> (fill_reg == '0 && !err_reg && m_valid_reg))
        else $error("graph state not cleared after result");
`endif

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: component pair counter testbench
// Streams directed graphs edge by edge into the block, predicts for each graph
// the number of distinct strongly connected component pairs joined by an edge
// and the load error flag, and checks every result word against it under
// random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb;
    import scc_pkg::*;

    localparam int LIMIT = 12_000_000;

    logic                 aclk = 0;
    logic                 aresetn = 0;
    logic                 cfg_valid = 0;
    logic                 cfg_ready;
    logic [CNT_W-1:0]     cfg_data = '0;
    logic                 s_tvalid = 0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 0;
    logic                 s_tlast = 0;
    logic                 m_tvalid;
    logic                 m_tready = 0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    typedef struct packed {
        logic [OUT_W-1:0] pair_count;
        logic             load_err;
    } pair_result_t;

    pair_result_t pair_result_q[$];
    logic [CNT_W-1:0] vtx_count = CNT_W'(MAX_VERTICES);
    int  tail_mem[MAX_EDGES];
    int  head_mem[MAX_EDGES];
    int  edge_fill = 0;
    bit  load_err = 0;
    int  gap_pct = 0;
    int  stall_pct = 0;
    int  hold_off = 0;
    int  cycle_cnt = 0;
    int  item_cnt = 0;
    bit  failed = 0;

    scc_condensation_edge_count DUT (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (hold_off > 0) begin
            m_tready <= 0;
            hold_off <= hold_off - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pair_result_q.size() == 0) begin
                $display("%0t: unexpected word count=%0d err=%0b", $time,
                         m_tdata[OUT_W-1:0], m_tuser);
                failed = 1;
            end else begin
                pair_result_t want;
                want = pair_result_q.pop_front();
                if (m_tdata[OUT_W-1:0] !== want.pair_count) begin
                    $display("%0t: pair count expected %0d actual %0d", $time,
                             want.pair_count, m_tdata[OUT_W-1:0]);
                    failed = 1;
                end
                if (m_tuser !== want.load_err) begin
                    $display("%0t: load error expected %0b actual %0b", $time,
                             want.load_err, m_tuser);
                    failed = 1;
                end
            end
        end
    end

    function automatic int eff_count();
        return (vtx_count > MAX_VERTICES) ? MAX_VERTICES : int'(vtx_count);
    endfunction

    // Kosaraju over the stored edge list; reversed walk swaps tail and head.
    function automatic int count_pairs();
        int  n, i, j, sp, done, color, cnt, v, w, a, b, t, h, pass;
        bit  vis[MAX_VERTICES];
        int  order[MAX_VERTICES];
        int  comp[MAX_VERTICES];
        int  stk_v[MAX_VERTICES];
        int  stk_p[MAX_VERTICES];
        bit  seen[int];
        n = eff_count();
        done = 0;
        color = 0;
        cnt = 0;
        for (i = 0; i < MAX_VERTICES; i++) begin
            vis[i] = 0;
            comp[i] = 0;
        end
        for (pass = 0; pass < 2; pass++) begin
            for (j = 0; j < ((pass == 0) ? n : done); j++) begin
                i = (pass == 0) ? j : order[done-1-j];
                if ((pass == 0) ? vis[i] : (comp[i] != 0))
                    continue;
                if (pass == 0) vis[i] = 1;
                else begin
                    color++;
                    comp[i] = color;
                end
                sp = 1;
                stk_v[0] = i;
                stk_p[0] = 0;
                while (sp > 0) begin
                    v = stk_v[sp-1];
                    w = -1;
                    while (stk_p[sp-1] < edge_fill && w < 0) begin
                        t = (pass == 0) ? tail_mem[stk_p[sp-1]] : head_mem[stk_p[sp-1]];
                        h = (pass == 0) ? head_mem[stk_p[sp-1]] : tail_mem[stk_p[sp-1]];
                        stk_p[sp-1]++;
                        if (t == v && t < n && h < n) w = h;
                    end
                    if (w >= 0) begin
                        if (pass == 0 && !vis[w]) begin
                            vis[w] = 1;
                            stk_v[sp] = w;
                            stk_p[sp] = 0;
                            sp++;
                        end else if (pass == 1 && comp[w] == 0) begin
                            comp[w] = color;
                            stk_v[sp] = w;
                            stk_p[sp] = 0;
                            sp++;
                        end
                    end else begin
                        sp--;
                        if (pass == 0) begin
                            order[done] = v;
                            done++;
                        end
                    end
                end
            end
        end
        for (i = 0; i < edge_fill; i++) begin
            if (tail_mem[i] >= n || head_mem[i] >= n)
                continue;
            a = comp[tail_mem[i]];
            b = comp[head_mem[i]];
            if (a == b || a == 0 || b == 0)
                continue;
            if (a > b) begin
                t = a;
                a = b;
                b = t;
            end
            if (!seen.exists(a * 1024 + b)) begin
                seen[a * 1024 + b] = 1;
                if (cnt < 4095) cnt++;
            end
        end
        return cnt;
    endfunction

    task automatic predict_word(int src, int dst, bit edge_ok, bit last);
        int n;
        pair_result_t r;
        n = eff_count();
        if (edge_ok) begin
            if (src < 1 || src > n || dst < 1 || dst > n || edge_fill >= MAX_EDGES)
                load_err = 1;
            else begin
                tail_mem[edge_fill] = src - 1;
                head_mem[edge_fill] = dst - 1;
                edge_fill++;
            end
        end
        if (last) begin
            r.pair_count = OUT_W'(count_pairs());
            r.load_err = load_err;
            pair_result_q = {pair_result_q, r};
            edge_fill = 0;
            load_err = 0;
        end
    endtask

    task automatic send_word(int src, int dst, bit edge_ok, bit last);
        s_tdata <= {6'b0, dst[IN_W-1:0], src[IN_W-1:0]};
        s_tuser <= edge_ok;
        s_tlast <= last;
        s_tvalid <= 1;
        do @(posedge aclk); while (!s_tready);
        item_cnt++;
        predict_word(src, dst, edge_ok, last);
        if ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (pair_result_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_vtx_count(int value);
        cfg_data <= value[CNT_W-1:0];
        cfg_valid <= 1;
        do @(posedge aclk); while (!cfg_ready);
        vtx_count = value[CNT_W-1:0];
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    task automatic test_directed();
        write_vtx_count(5);
        send_word(1, 2, 1, 0);
        send_word(2, 3, 1, 0);
        send_word(3, 1, 1, 0);
        send_word(3, 4, 1, 0);
        send_word(4, 5, 1, 0);
        send_word(5, 4, 1, 0);
        send_word(0, 0, 0, 0);
        send_word(2, 4, 1, 1);
        send_word(0, 0, 0, 1);
        send_word(0, 3, 1, 0);
        send_word(2, 6, 1, 0);
        send_word(1, 1, 1, 1);
        drain();
        write_vtx_count(256);
        send_word(256, 1, 1, 0);
        send_word(1, 256, 1, 0);
        send_word(255, 256, 1, 0);
        send_word(511, 511, 1, 1);
        drain();
        write_vtx_count(511);
        send_word(256, 128, 1, 1);
        drain();
        write_vtx_count(0);
        send_word(1, 1, 1, 1);
        drain();
        write_vtx_count(1);
        send_word(1, 1, 1, 1);
        drain();
        write_vtx_count(8);
        send_word(7, 8, 1, 0);
        send_word(1, 2, 1, 0);
        drain();
        write_vtx_count(4);
        send_word(2, 1, 1, 1);
        drain();
    endtask

    task automatic test_capacity();
        write_vtx_count(2);
        for (int i = 0; i < MAX_EDGES; i++)
            send_word(1 + (i % 2), 2 - ((i / 2) % 2), 1, 0);
        send_word(2, 1, 1, 1);
        drain();
    endtask

    task automatic send_graph();
        int n, k, src, dst;
        n = eff_count();
        k = $urandom_range(1, 12);
        for (int i = 0; i < k; i++) begin
            if ($urandom_range(99) < 4) begin
                src = $urandom_range(0, 511);
                dst = $urandom_range(0, 511);
            end else begin
                src = $urandom_range(1, (n < 1) ? 1 : n);
                dst = $urandom_range(1, (n < 1) ? 1 : n);
            end
            if ($urandom_range(99) < 3)
                send_word(src, dst, 0, 0);
            send_word(src, dst, $urandom_range(99) < 95, i == k - 1);
        end
    endtask

    task automatic test_random(int items, int gp, int sp);
        int start;
        gap_pct = gp;
        stall_pct = sp;
        start = item_cnt;
        while (item_cnt - start < items) begin
            if ($urandom_range(99) < 20) begin
                drain();
                case ($urandom_range(9))
                    0: write_vtx_count(256);
                    1: write_vtx_count(1);
                    default: write_vtx_count($urandom_range(2, 16));
                endcase
            end
            send_graph();
        end
        drain();
    endtask

    task automatic test_backpressure();
        gap_pct = 0;
        stall_pct = 0;
        write_vtx_count(6);
        hold_off = 3000;
        repeat (5) send_graph();
        drain();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        test_directed();
        test_capacity();
        test_random(80, 0, 0);
        test_random(80, 61, 0);
        test_random(80, 0, 61);
        test_random(80, 23, 23);
        test_backpressure();
        if (!failed)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
